### design/rbd_pkg.sv
// rbd_pkg: shared constants, types and pointer helpers for the ring buffer deque
// no dependencies; imported by rbd_ctrl, rbd_dp and ring_buffer_deque_top

package rbd_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int OP_WIDTH    = 3;
    localparam int INDEX_WIDTH = 4;
    localparam int STAT_WIDTH  = 2;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = ((PTR_W > INDEX_WIDTH) ? PTR_W : INDEX_WIDTH) + 1;
    localparam int CMP_W       = (CNT_W > INDEX_WIDTH) ? CNT_W : INDEX_WIDTH;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_GET        = 3'd6
    } opcode_t;

    typedef enum logic [STAT_WIDTH-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } rbd_cmd_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

endpackage

### design/ring_buffer_deque_top.sv
// ring_buffer_deque_top: an input transaction is loaded into the operand registers,
// then the single execute step on the slot store loads the result registers, which
// hold until taken with m_ready; s_ready stays low, so no new transaction is accepted
// before that; synchronous active-low reset clears pointers, count and sequencer; slots are
// not cleared and hold garbage until written
// depends on rbd_pkg, rbd_ctrl, rbd_dp

module ring_buffer_deque_top import rbd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_WIDTH-1:0]    s_opcode,
    input  logic [DATA_WIDTH-1:0]  s_value,
    input  logic [INDEX_WIDTH-1:0] s_index,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DATA_WIDTH-1:0]  m_data,
    output logic [STAT_WIDTH-1:0]  m_status,
    output logic [CNT_W-1:0]       m_occupancy
);

    rbd_cmd_t cmd;

    rbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rbd_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_opcode    (s_opcode),
        .s_value     (s_value),
        .s_index     (s_index),
        .m_data      (m_data),
        .m_status    (m_status),
        .m_occupancy (m_occupancy)
    );

endmodule

### design/rbd_ctrl.sv
// rbd_ctrl: transaction sequencer for the ring buffer deque
// depends on rbd_pkg; drives load and execute commands into rbd_dp

module rbd_ctrl import rbd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output rbd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_DONE);
    assign cmd.load = s_valid && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

### design/rbd_dp.sv
// rbd_dp: slot store, head/tail pointers, count and result registers
// depends on rbd_pkg; commanded by rbd_ctrl

module rbd_dp import rbd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rbd_cmd_t               cmd,
    input  logic [OP_WIDTH-1:0]    s_opcode,
    input  logic [DATA_WIDTH-1:0]  s_value,
    input  logic [INDEX_WIDTH-1:0] s_index,
    output logic [DATA_WIDTH-1:0]  m_data,
    output logic [STAT_WIDTH-1:0]  m_status,
    output logic [CNT_W-1:0]       m_occupancy
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [OP_WIDTH-1:0]    op_reg;
    logic [DATA_WIDTH-1:0]  value_reg;
    logic [INDEX_WIDTH-1:0] index_reg;

    ptr_t head_reg, head_next;
    ptr_t tail_reg, tail_next;
    cnt_t count_reg, count_next;

    logic [DATA_WIDTH-1:0] rd_data_reg;
    status_t               status_reg, status_next;
    cnt_t                  occ_reg;
    logic                  use_mem_reg, use_mem_next;
    logic                  zero_reg, zero_next;

    logic       wr_en, rd_en;
    ptr_t       wr_addr, rd_addr, get_addr;
    logic       empty, full, idx_ok;
    logic [SUM_W-1:0] get_sum;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign idx_ok = (CMP_W'(index_reg) < CMP_W'(count_reg));

    always_comb begin
        get_sum = SUM_W'(head_reg) + SUM_W'(index_reg);
        if (get_sum >= SUM_W'(DEPTH)) begin
            get_sum = get_sum - SUM_W'(DEPTH);
        end
        get_addr = get_sum[PTR_W-1:0];
    end

    always_comb begin
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_addr      = head_reg;
        rd_addr      = head_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        status_next  = STAT_ERR;
        use_mem_next = 1'b0;
        zero_next    = 1'b0;
        unique case (op_reg)
            OP_PUSH_FRONT: begin
                zero_next = 1'b1;
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en       = 1'b1;
                    wr_addr     = ptr_dec(head_reg);
                    head_next   = wr_addr;
                    tail_next   = empty ? wr_addr : tail_reg;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = STAT_OK;
                end
            end
            OP_PUSH_BACK: begin
                zero_next = 1'b1;
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en       = 1'b1;
                    wr_addr     = ptr_inc(tail_reg);
                    tail_next   = wr_addr;
                    head_next   = empty ? wr_addr : head_reg;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = STAT_OK;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (!empty) begin
                    rd_en        = 1'b1;
                    rd_addr      = head_reg;
                    use_mem_next = 1'b1;
                    status_next  = STAT_OK;
                    if (op_reg == OP_POP_FRONT) begin
                        head_next  = ptr_inc(head_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (!empty) begin
                    rd_en        = 1'b1;
                    rd_addr      = tail_reg;
                    use_mem_next = 1'b1;
                    status_next  = STAT_OK;
                    if (op_reg == OP_POP_BACK) begin
                        tail_next  = ptr_dec(tail_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            OP_GET: begin
                if (idx_ok) begin
                    rd_en        = 1'b1;
                    rd_addr      = get_addr;
                    use_mem_next = 1'b1;
                    status_next  = STAT_OK;
                end
            end
            default: begin
                status_next = STAT_ERR;
            end
        endcase
    end

    // operand capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_opcode;
            value_reg <= s_value;
            index_reg <= s_index;
        end
    end

    // slot store
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.exec && rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg  <= status_next;
            occ_reg     <= count_next;
            use_mem_reg <= use_mem_next;
            zero_reg    <= zero_next;
        end
    end

    assign m_data      = use_mem_reg ? rd_data_reg : (zero_reg ? '0 : '1);
    assign m_status    = status_reg;
    assign m_occupancy = occ_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above capacity");

    a_full_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && full && (op_reg == OP_PUSH_FRONT || op_reg == OP_PUSH_BACK)
        |=> count_reg == $past(count_reg) && head_reg == $past(head_reg)
            && tail_reg == $past(tail_reg))
        else $error("refused push changed state");

    a_pop_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && !empty && (op_reg == OP_POP_FRONT || op_reg == OP_POP_BACK)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not decrement count");

    a_single_ptrs_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'(1) |-> head_reg == tail_reg)
        else $error("head and tail differ with one word stored");

endmodule
